// ===== design/dtdt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtdt_pkg: shared types and constants for the dual timestamp delay tracker
// Item structs, status codes and gap fixup limits.
// ----------------------------------------------------------------------------
package dtdt_pkg;

  localparam int TS_W   = 32;
  localparam int GAP_W  = 16;
  localparam int SUM_W  = 64;
  localparam int DIFF_W = 35;

  typedef logic signed [DIFF_W-1:0] diff_t;

  localparam logic [1:0] ST_SAMPLE   = 2'd0;
  localparam logic [1:0] ST_SKIP     = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_STOPPED  = 2'd3;

  localparam diff_t FIX_LO_LIM  = -35'sd2304;   // -0x900
  localparam diff_t FIX_HI_LIM  = -35'sd4352;   // -0x1100
  localparam diff_t FIX_STEP    = 35'sd4096;    // 0x1000
  localparam diff_t BROKEN_LIM  = 35'sd128;     // 0x80
  localparam int    FIX_BIT     = 12;

  typedef struct packed {
    logic [TS_W-1:0] tx_time_a;
    logic [TS_W-1:0] rx_time_a;
    logic [TS_W-1:0] tx_time_b;
    logic [TS_W-1:0] rx_time_b;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TS_W-1:0]  delay_a;
    logic [TS_W-1:0]  delay_b;
    logic [TS_W-1:0]  delay_min;
    logic             tx_fixed;
    logic             tx_broken;
    logic             notif_flag;
    logic [TS_W-1:0]  samples_taken;
    logic [TS_W-1:0]  notifs_seen;
    logic [TS_W-1:0]  running_min;
    logic [TS_W-1:0]  running_max;
    logic [SUM_W-1:0] min_sum;
  } out_t;

endpackage

// ===== design/dual_timestamp_delay_tracker.sv =====
// ----------------------------------------------------------------------------
// dual_timestamp_delay_tracker: per-sample delay and running statistics
// Two-device transmit/receive stamp pairs in, one result item out per item.
// ----------------------------------------------------------------------------
// Each input item passes through an input register and one stage of logic into
// the result register, so the block takes one item per cycle when the output
// is not stalled; a stalled output holds the item in the input register.
// The rate is set by the update of the previous-sample and statistics
// registers, which items read and write. Mismatched nonzero transmit
// stamps put the block in a stopped state that only reset clears. ifg_gap
// is to be written through cfg only while idle; the block does not enforce it.
module dual_timestamp_delay_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtdt_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtdt_pkg::out_t       out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import dtdt_pkg::*;

  logic              in_full;
  in_t               in_reg;
  logic              advance;

  logic [GAP_W-1:0]  ifg_gap;
  logic [TS_W-1:0]   prev_tx, prev_tx_next;
  logic [TS_W-1:0]   prev_rx_a, prev_rx_a_next;
  logic [TS_W-1:0]   prev_rx_b, prev_rx_b_next;
  logic              first_pending, first_pending_next;
  logic              halted, halted_next;
  logic [TS_W-1:0]   sample_total, sample_total_next;
  logic [TS_W-1:0]   notif_total, notif_total_next;
  logic [TS_W-1:0]   min_seen, min_seen_next;
  logic [TS_W-1:0]   max_seen, max_seen_next;
  logic [SUM_W-1:0]  min_sum_acc, min_sum_acc_next;

  logic              notif, mismatch, skip, gap_on, fix, broken;
  logic [TS_W-1:0]   tx, tx_f, d_a, d_b, mn, mx;
  logic [TS_W:0]     tx_u;
  diff_t             diff, diff_alt, diff_used;
  out_t              res;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  always_comb begin
    notif    = (in_reg.tx_time_a == '0) || (in_reg.tx_time_b == '0);
    mismatch = !notif && (in_reg.tx_time_a != in_reg.tx_time_b);
    tx       = (in_reg.tx_time_a != '0) ? in_reg.tx_time_a : in_reg.tx_time_b;
    skip     = (tx == '0);
    tx_u     = {prev_tx[TS_W-1] & ~tx[TS_W-1], tx};
    diff     = diff_t'({3'b000, prev_tx}) + diff_t'({19'd0, ifg_gap})
             - diff_t'({2'b00, tx_u});
    diff_alt = tx[FIX_BIT] ? (diff + FIX_STEP) : (diff - FIX_STEP);
    gap_on   = (ifg_gap != '0) && !first_pending;
    fix      = gap_on && (diff < FIX_LO_LIM) && (diff > FIX_HI_LIM);
    diff_used = fix ? diff_alt : diff;
    broken   = gap_on && ((diff_used < -BROKEN_LIM) || (diff_used > BROKEN_LIM));
    tx_f     = tx ^ (TS_W'(fix) << FIX_BIT);
    d_a      = in_reg.rx_time_a - tx_f;
    d_b      = in_reg.rx_time_b - tx_f;
    mn       = (d_a < d_b) ? d_a : d_b;
    mx       = (d_a < d_b) ? d_b : d_a;

    prev_tx_next       = prev_tx;
    prev_rx_a_next     = prev_rx_a;
    prev_rx_b_next     = prev_rx_b;
    first_pending_next = first_pending;
    halted_next        = halted;
    sample_total_next  = sample_total;
    notif_total_next   = notif_total;
    min_seen_next      = min_seen;
    max_seen_next      = max_seen;
    min_sum_acc_next   = min_sum_acc;

    res            = '0;
    res.status     = ST_SAMPLE;

    if (halted) begin
      res.status = ST_STOPPED;
    end else if (mismatch) begin
      res.status = ST_MISMATCH;
      if (advance) halted_next = 1'b1;
    end else begin
      res.notif_flag = notif;
      if (advance && notif) notif_total_next = notif_total + 1'b1;
      if (skip) begin
        res.status = ST_SKIP;
      end else begin
        res.delay_a   = d_a;
        res.delay_b   = d_b;
        res.delay_min = mn;
        res.tx_fixed  = fix;
        res.tx_broken = broken;
        if (advance) begin
          sample_total_next  = sample_total + 1'b1;
          min_sum_acc_next   = min_sum_acc + {{(SUM_W-TS_W){1'b0}}, mn};
          if (mn < min_seen) min_seen_next = mn;
          if (mx > max_seen) max_seen_next = mx;
          prev_tx_next       = tx_f;
          prev_rx_a_next     = in_reg.rx_time_a;
          prev_rx_b_next     = in_reg.rx_time_b;
          first_pending_next = 1'b0;
        end
      end
    end

    res.samples_taken = sample_total_next;
    res.notifs_seen   = notif_total_next;
    res.running_min   = min_seen_next;
    res.running_max   = max_seen_next;
    res.min_sum       = min_sum_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      ifg_gap       <= '0;
      prev_tx       <= '0;
      prev_rx_a     <= '0;
      prev_rx_b     <= '0;
      first_pending <= 1'b1;
      halted        <= 1'b0;
      sample_total  <= '0;
      notif_total   <= '0;
      min_seen      <= '1;
      max_seen      <= '0;
      min_sum_acc   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) ifg_gap <= cfg_data;
      if (in_ready) in_full <= in_valid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      prev_tx       <= prev_tx_next;
      prev_rx_a     <= prev_rx_a_next;
      prev_rx_b     <= prev_rx_b_next;
      first_pending <= first_pending_next;
      halted        <= halted_next;
      sample_total  <= sample_total_next;
      notif_total   <= notif_total_next;
      min_seen      <= min_seen_next;
      max_seen      <= max_seen_next;
      min_sum_acc   <= min_sum_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= in_data;
    if (advance) out_data <= res;
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("stopped state left without reset");

  a_no_count_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(sample_total) && $stable(notif_total) && $stable(min_sum_acc))
    else $error("statistics changed without an item");

  a_min_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_SAMPLE |->
      out_data.delay_min <= out_data.delay_a && out_data.delay_min <= out_data.delay_b
      && out_data.running_min <= out_data.delay_min)
    else $error("minimum delay inconsistent");

  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_STOPPED |->
      out_data.delay_a == '0 && out_data.tx_fixed == 1'b0 && out_data.notif_flag == 1'b0)
    else $error("stopped item carries sample fields");

endmodule
